FILE: sv/bpra_pkg.sv
// shared types and constants for the bitmap page run allocator
`timescale 1ns / 1ps
package bpra_pkg;
  localparam int MAX_PAGES = 4096;
  localparam int MAX_RUN   = 64;
  localparam int PG_W      = $clog2(MAX_PAGES);
  localparam int GRP_W     = PG_W - 3;
  localparam int GROUPS    = MAX_PAGES / 8;
  localparam int CNT_W     = 13;
  localparam int VPN_W     = 20;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_OUTSIDE = 2'd2
  } status_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    REG_BASE_PAGE  = 2'd0,
    REG_PAGE_COUNT = 2'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_RUN_RD, ST_RUN_CHK,
    ST_MARK_RD, ST_MARK_WR, ST_FREE_RD, ST_FREE_WR, ST_DONE
  } state_t;

  typedef struct packed {
    logic             func;
    logic [6:0]       run_length;
    logic [VPN_W-1:0] page_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VPN_W-1:0] first_page;
  } out_item_t;
endpackage

FILE: sv/bitmap_page_run_allocator_unit.sv
// top level of the bitmap first-fit page run allocator
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | in_data   (func, run_length, page_number)
//  out     | out_valid/out_stall| out_data  (status, first_page)
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// bitmap lives in a 512 x 8 ram, one 8-page group per row; a row visit reads, then checks or writes
// alloc: scans groups from the hint for one not full, searches for the run, marks its groups
// free: reads and rewrites one row; a result waits in the output register while the next item runs
// after reset a clearing pass over every row holds in_stall high; cfg writes always taken
// out_stall only delays the hand-off of a finished result
`timescale 1ns / 1ps
module bitmap_page_run_allocator_unit
  import bpra_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  state_t state_r, state_nxt;
  logic [VPN_W-1:0] base_page_r;
  logic [CNT_W-1:0] page_count_r;
  logic [GRP_W-1:0] hint_r, hint_nxt;
  logic [GRP_W:0]   g_r, g_nxt, clr_r;
  logic [6:0]       n_r, n_nxt, run_r, run_nxt;
  logic [PG_W-1:0]  start_r, start_nxt, end_r, end_nxt, idx_r, idx_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic [VPN_W-1:0] res_first_r, res_first_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic [CNT_W-1:0] count;
  logic [GRP_W:0]   groups;
  logic             we;
  logic [GRP_W-1:0] waddr, raddr;
  logic [7:0]       wdata, rdata;
  logic [7:0]       pad, mark_mask;
  logic [6:0]       run_v, n_in;
  logic             found_v;
  logic [PG_W-1:0]  fp_v, start_v, p_k;
  logic [VPN_W-1:0] idx_full;
  logic             load_out;

  assign count  = (page_count_r > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : page_count_r;
  assign groups = (GRP_W+1)'((count + CNT_W'(7)) >> 3);

  bpra_ram #(.WIDTH(8), .DEPTH(GROUPS)) u_map (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign n_in      = (in_data.run_length == 7'd0) ? 7'd1 : in_data.run_length;
  assign idx_full  = in_data.page_number - base_page_r;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    run_v   = run_r;
    found_v = 1'b0;
    fp_v    = '0;
    for (int k = 0; k < 8; k++) begin
      p_k    = {g_r[GRP_W-1:0], 3'(k)};
      pad[k] = ({1'b0, p_k} >= count);
      mark_mask[k] = (p_k >= start_r) && (p_k <= end_r);
      if (!found_v) begin
        if (rdata[k] || pad[k]) begin
          run_v = 7'd0;
        end else begin
          run_v = run_v + 7'd1;
          if (run_v == n_r) begin
            found_v = 1'b1;
            fp_v    = p_k;
          end
        end
      end
    end
    start_v = fp_v - PG_W'(n_r) + PG_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      hint_r       <= '0;
      base_page_r  <= '0;
      page_count_r <= CNT_W'(4096);
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hint_r  <= hint_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BASE_PAGE) base_page_r <= cfg_data[VPN_W-1:0];
        else if (cfg_index == REG_PAGE_COUNT) page_count_r <= cfg_data[CNT_W-1:0];
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    g_r          <= g_nxt;
    n_r          <= n_nxt;
    run_r        <= run_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_first_r  <= res_first_nxt;
    if (load_out) out_data_r <= '{status: res_status_r, first_page: res_first_r};
  end

  always_comb begin
    state_nxt      = state_r;
    hint_nxt       = hint_r;
    g_nxt          = g_r;
    n_nxt          = n_r;
    run_nxt        = run_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_first_nxt  = res_first_r;
    we    = 1'b0;
    waddr = g_r[GRP_W-1:0];
    wdata = '0;
    raddr = g_r[GRP_W-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r[GRP_W-1:0];
        if (clr_r == (GRP_W+1)'(GROUPS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          res_status_nxt = STAT_NOSPACE;
          res_first_nxt  = '0;
          if (in_data.func == FUNC_ALLOC) begin
            n_nxt = n_in;
            g_nxt = {1'b0, hint_r};
            if (n_in > 7'(MAX_RUN) || {1'b0, hint_r} >= groups) state_nxt = ST_DONE;
            else state_nxt = ST_SCAN_RD;
          end else begin
            idx_nxt = idx_full[PG_W-1:0];
            if (idx_full >= VPN_W'(count)) begin
              res_status_nxt = STAT_OUTSIDE;
              state_nxt      = ST_DONE;
            end else begin
              g_nxt     = {1'b0, idx_full[PG_W-1:3]};
              state_nxt = ST_FREE_RD;
            end
          end
        end
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if ((rdata | pad) != 8'hff) begin
          hint_nxt  = g_r[GRP_W-1:0];
          run_nxt   = '0;
          state_nxt = ST_RUN_RD;
        end else begin
          g_nxt     = g_r + 1'b1;
          state_nxt = (g_r + 1'b1 >= groups) ? ST_DONE : ST_SCAN_RD;
        end
      end
      ST_RUN_RD: state_nxt = ST_RUN_CHK;
      ST_RUN_CHK: begin
        run_nxt = run_v;
        if (found_v) begin
          start_nxt = start_v;
          end_nxt   = fp_v;
          g_nxt     = {1'b0, start_v[PG_W-1:3]};
          state_nxt = ST_MARK_RD;
        end else begin
          g_nxt     = g_r + 1'b1;
          state_nxt = (g_r + 1'b1 >= groups) ? ST_DONE : ST_RUN_RD;
        end
      end
      ST_MARK_RD: state_nxt = ST_MARK_WR;
      ST_MARK_WR: begin
        we    = 1'b1;
        wdata = rdata | mark_mask;
        if (g_r[GRP_W-1:0] == end_r[PG_W-1:3]) begin
          res_status_nxt = STAT_DONE;
          res_first_nxt  = base_page_r + VPN_W'(start_r);
          state_nxt      = ST_DONE;
        end else begin
          g_nxt     = g_r + 1'b1;
          state_nxt = ST_MARK_RD;
        end
      end
      ST_FREE_RD: state_nxt = ST_FREE_WR;
      ST_FREE_WR: begin
        we    = 1'b1;
        wdata = rdata & ~(8'd1 << idx_r[2:0]);
        if (idx_r[PG_W-1:3] < hint_r) hint_nxt = idx_r[PG_W-1:3];
        res_status_nxt = STAT_DONE;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted item did not make the block busy");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside done state");
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == ST_CLEAR || state_r == ST_MARK_WR || state_r == ST_FREE_WR))
    else $error("bitmap write in wrong state");
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("input taken during clearing pass");
`endif
endmodule

FILE: sv/bpra_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module bpra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: tb/sv/tb_top.sv
// testbench for the bitmap page run allocator: scoreboard model, directed and random traffic
`timescale 1ns / 1ps
module tb_top;
  import bpra_pkg::*;

  class page_alloc_scoreboard;
    bit          used_map[MAX_PAGES];
    int unsigned hint;
    logic [19:0] base;
    logic [12:0] count_reg;
    out_item_t   pending[$];
    int          errors;
    int          checked;

    function void clear_state();
      foreach (used_map[i]) used_map[i] = 1'b0;
      hint = 0;
      base = '0;
      count_reg = 13'd4096;
      errors = 0;
      checked = 0;
    endfunction

    function bit is_taken(int unsigned p, int unsigned live);
      if (p >= live) return 1'b1;
      return used_map[p];
    endfunction

    function void note_input(in_item_t it);
      out_item_t   r;
      int unsigned live, groups, g, p, run, n, idx, start;
      bit          group_full, found;
      r.status = STAT_NOSPACE;
      r.first_page = '0;
      live = (count_reg < MAX_PAGES) ? count_reg : MAX_PAGES;
      groups = (live + 7) / 8;
      if (it.func == FUNC_ALLOC) begin
        n = (it.run_length == 0) ? 1 : it.run_length;
        if (n <= MAX_RUN) begin
          found = 1'b0;
          for (g = hint; g < groups; g++) begin
            group_full = 1'b1;
            for (int k = 0; k < 8; k++)
              if (!is_taken(g * 8 + k, live)) group_full = 1'b0;
            if (!group_full) begin
              found = 1'b1;
              break;
            end
          end
          if (found) begin
            hint = g;
            run = 0;
            for (p = g * 8; p < live; p++) begin
              if (used_map[p]) begin
                run = 0;
                continue;
              end
              run++;
              if (run == n) begin
                start = p + 1 - n;
                for (int q = start; q <= p; q++) used_map[q] = 1'b1;
                r.status = STAT_DONE;
                r.first_page = base + start[19:0];
                break;
              end
            end
          end
        end
      end else begin
        idx = 20'(it.page_number - base);
        if (idx >= live) r.status = STAT_OUTSIDE;
        else begin
          used_map[idx] = 1'b0;
          if (idx / 8 < hint) hint = idx / 8;
          r.status = STAT_DONE;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d first_page=%h", $time, got.status,
                 got.first_page);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.first_page !== want.first_page) begin
        $display("%0t: first_page expected %h actual %h", $time, want.first_page,
                 got.first_page);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  page_alloc_scoreboard sb;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          sent;
  logic [19:0] given_pages[$];

  bitmap_page_run_allocator_unit uut (.*);

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
      if (out_data.status == STAT_DONE && out_data.first_page != 0)
        given_pages.push_back(out_data.first_page);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BASE_PAGE) sb.base = val[19:0];
    else sb.count_reg = val[12:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(logic f, logic [6:0] len, logic [19:0] pg);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{func: f, run_length: len, page_number: pg};
    do @(posedge clk); while (in_stall);
    sb.note_input(in_data);
    sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic random_traffic(int n);
    logic [19:0] pg;
    repeat (n) begin
      if ($urandom_range(99) < 55) begin
        case ($urandom_range(9))
          0: send_item(FUNC_ALLOC, 7'($urandom_range(127)), 20'($urandom));
          1, 2: send_item(FUNC_ALLOC, 7'($urandom_range(64)), 20'($urandom));
          default: send_item(FUNC_ALLOC, 7'($urandom_range(6)), 20'($urandom));
        endcase
      end else begin
        if (given_pages.size() != 0 && $urandom_range(99) < 70) begin
          pg = given_pages[$urandom_range(given_pages.size() - 1)];
          pg = pg + 20'($urandom_range(3));
        end else if ($urandom_range(1)) pg = sb.base + 20'($urandom_range(4200));
        else pg = 20'($urandom);
        send_item(FUNC_FREE, 7'($urandom), pg);
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    send_idle_pct = 27;
    recv_idle_pct = 77;
    sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes and special cases on the reset region
    send_item(FUNC_ALLOC, 7'd0, 20'hfffff);
    send_item(FUNC_ALLOC, 7'd64, 20'd0);
    send_item(FUNC_ALLOC, 7'd65, 20'd0);
    send_item(FUNC_ALLOC, 7'd127, 20'd0);
    send_item(FUNC_ALLOC, 7'd7, 20'd0);
    send_item(FUNC_FREE, 7'd127, 20'd3);
    send_item(FUNC_FREE, 7'd0, 20'd3);
    send_item(FUNC_FREE, 7'd0, 20'd4096);
    send_item(FUNC_FREE, 7'd0, 20'hfffff);
    send_item(FUNC_FREE, 7'd0, 20'd4095);
    send_item(FUNC_ALLOC, 7'd1, 20'd0);
    send_item(FUNC_ALLOC, 7'd2, 20'd0);
    drain();

    // wrapping region with a partial last group
    write_reg(REG_BASE_PAGE, 32'hffffc);
    write_reg(REG_PAGE_COUNT, 32'd21);
    send_item(FUNC_ALLOC, 7'd20, 20'd0);
    send_item(FUNC_ALLOC, 7'd2, 20'd0);
    send_item(FUNC_ALLOC, 7'd1, 20'd0);
    send_item(FUNC_ALLOC, 7'd1, 20'd0);
    send_item(FUNC_FREE, 7'd0, 20'h00002);
    send_item(FUNC_FREE, 7'd0, 20'hffffb);
    send_item(FUNC_ALLOC, 7'd1, 20'd0);
    drain();

    // empty region
    write_reg(REG_PAGE_COUNT, 32'd0);
    send_item(FUNC_ALLOC, 7'd1, 20'd0);
    send_item(FUNC_FREE, 7'd0, 20'hffffc);
    drain();

    write_reg(REG_BASE_PAGE, 32'h12340);
    write_reg(REG_PAGE_COUNT, 32'd96);
    random_traffic(450);
    drain();

    send_idle_pct = 77;
    recv_idle_pct = 27;
    write_reg(REG_BASE_PAGE, 32'hfff00);
    write_reg(REG_PAGE_COUNT, 32'd8191);
    random_traffic(450);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_BASE_PAGE, 32'h00000);
    write_reg(REG_PAGE_COUNT, 32'd37);
    random_traffic(450);
    drain();

    $display("covered %0d requests, %0d results checked over six region settings", sent,
             sb.checked);
    $display("alloc and free with wrap, partial groups, empty and oversized regions");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("bitmap_page_run_allocator_unit verification clean");
    else
      $display("bitmap_page_run_allocator_unit verification failed");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("bitmap_page_run_allocator_unit verification failed");
    $finish;
  end
endmodule
